// ----- rtl/mi3_pkg.sv -----
// Shared types, widths and the truncate-and-saturate helper for the 3x3 inverse.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mi3_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ELEM_WIDTH = 32;

   // Wide accumulator: enough for the sum of three full products plus sign.
   localparam int ACC_W   = 2 * ELEM_WIDTH + 4;
   // Reciprocal quotient bits and the signed reciprocal width.
   localparam int Q_W     = 2 * FRAC_BITS + 1;
   localparam int RCP_W   = Q_W + 1;
   // Pipeline depths of the parts.
   localparam int DIV_LAT = Q_W + 2;
   localparam int COF_DLY = DIV_LAT + 2;
   localparam int DET_DLY = DIV_LAT + 1;
   localparam int LATENCY = DIV_LAT + 7;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] RND_ADD =
      {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [RCP_W-1:0] recip_type;

   typedef struct packed {
      elem_type m00; elem_type m01; elem_type m02;
      elem_type m10; elem_type m11; elem_type m12;
      elem_type m20; elem_type m21; elem_type m22;
   } req_type;

   typedef struct packed {
      elem_type r00; elem_type r01; elem_type r02;
      elem_type r10; elem_type r11; elem_type r12;
      elem_type r20; elem_type r21; elem_type r22;
      elem_type det_out;
      logic     singular;
      logic     overflow;
   } rsp_type;

   typedef struct packed {
      elem_type val;
      logic     ovf;
   } sat_type;

   typedef struct packed {
      elem_type det;
      logic     ovf;
   } det_bundle_type;

   // Divide by 2^FRAC_BITS rounding towards zero, then clamp to the element range.
   function automatic sat_type trunc_sat(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] b;
      logic signed [ACC_W-1:0] t;
      sat_type r;
      b = x + (x[ACC_W-1] ? RND_ADD : '0);
      t = b >>> FRAC_BITS;
      if (t > SAT_HI) begin
         r.val = SAT_HI[ELEM_WIDTH-1:0];
         r.ovf = 1'b1;
      end else if (t < SAT_LO) begin
         r.val = SAT_LO[ELEM_WIDTH-1:0];
         r.ovf = 1'b1;
      end else begin
         r.val = t[ELEM_WIDTH-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/matrix3_inverse_adjugate.sv -----
// Top level of the 3x3 adjugate inverse: lanes, determinant merge, divider, output.
// Depends on mi3_pkg and all mi3_ submodules.
//
//   channel | ports                           | direction
//   req     | req_valid req_stall req_data    | in  (matrix word)
//   rsp     | rsp_valid rsp_stall rsp_data    | out (inverse, determinant, flags)
//
// One word is accepted per cycle unless a stall on rsp freezes the pipeline; the
// divider, which resolves one quotient bit per stage, makes up most of the pipeline.
// Reset clears only the valid chain. A stall on rsp while a word waits freezes
// the whole pipeline and raises req_stall in the same cycle.
`default_nettype none

module matrix3_inverse_adjugate (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mi3_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mi3_pkg::rsp_type      rsp_data
);
   import mi3_pkg::*;

   logic                 en;
   logic [LATENCY-1:0]   valid_ff;
   req_type              req_ff;
   elem_type             mat [0:2][0:2];
   elem_type             cof [0:8];
   logic [8:0]           cof_ovf;
   det_bundle_type       det_b;
   recip_type            recip;
   elem_type             cof_dly_ff [0:COF_DLY-1][0:8];
   det_bundle_type       det_dly_ff [0:DET_DLY-1];
   det_bundle_type       det_out_ff;
   logic                 sing_ff;
   logic                 sing_now;
   elem_type             inv [0:8];
   logic [8:0]           inv_ovf;

   assign en        = !(valid_ff[LATENCY-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = valid_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      mat[0][0] = req_ff.m00; mat[0][1] = req_ff.m01; mat[0][2] = req_ff.m02;
      mat[1][0] = req_ff.m10; mat[1][1] = req_ff.m11; mat[1][2] = req_ff.m12;
      mat[2][0] = req_ff.m20; mat[2][1] = req_ff.m21; mat[2][2] = req_ff.m22;
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R0 = (i == 0) ? 1 : 0;
         localparam int R1 = (i == 2) ? 1 : 2;
         localparam int C0 = (j == 0) ? 1 : 0;
         localparam int C1 = (j == 2) ? 1 : 2;
         mi3_cof_lane u_cof (
            .clock    (clock),
            .en       (en),
            .sign_neg (((i + j) % 2) == 1),
            .a        (mat[R0][C0]),
            .b        (mat[R0][C1]),
            .c        (mat[R1][C0]),
            .d        (mat[R1][C1]),
            .cof      (cof[i*3+j]),
            .ovf      (cof_ovf[i*3+j])
         );
      end
   end

   // Row 0 of the matrix passes through row_ff[0] and row_ff[1] to line up with the cofactors.
   elem_type row_ff [0:1][0:2];
   always_ff @(posedge clock) begin
      if (en) begin
         row_ff[0][0] <= req_ff.m00;
         row_ff[0][1] <= req_ff.m01;
         row_ff[0][2] <= req_ff.m02;
         row_ff[1]    <= row_ff[0];
      end
   end

   mi3_det_merge u_det (
      .clock   (clock),
      .en      (en),
      .e0      (row_ff[1][0]),
      .e1      (row_ff[1][1]),
      .e2      (row_ff[1][2]),
      .c0      (cof[0]),
      .c1      (cof[1]),
      .c2      (cof[2]),
      .cof_ovf (|cof_ovf),
      .det     (det_b)
   );

   mi3_recip_div u_div (
      .clock (clock),
      .en    (en),
      .det   (det_b.det),
      .recip (recip)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         cof_dly_ff[0] <= cof;
         for (int k = 1; k < COF_DLY; k++) begin
            cof_dly_ff[k] <= cof_dly_ff[k-1];
         end
         det_dly_ff[0] <= det_b;
         for (int k = 1; k < DET_DLY; k++) begin
            det_dly_ff[k] <= det_dly_ff[k-1];
         end
         det_out_ff <= det_dly_ff[DET_DLY-1];
         sing_ff    <= sing_now;
      end
   end

   assign sing_now = (det_dly_ff[DET_DLY-1].det == '0);

   for (genvar i = 0; i < 3; i++) begin : g_irow
      for (genvar j = 0; j < 3; j++) begin : g_icol
         // The adjugate is the transposed cofactor matrix.
         mi3_inv_lane u_inv (
            .clock    (clock),
            .en       (en),
            .adj      (cof_dly_ff[COF_DLY-1][j*3+i]),
            .recip    (recip),
            .singular (sing_now),
            .res      (inv[i*3+j]),
            .ovf      (inv_ovf[i*3+j])
         );
      end
   end

   always_comb begin
      rsp_data.r00      = inv[0];
      rsp_data.r01      = inv[1];
      rsp_data.r02      = inv[2];
      rsp_data.r10      = inv[3];
      rsp_data.r11      = inv[4];
      rsp_data.r12      = inv[5];
      rsp_data.r20      = inv[6];
      rsp_data.r21      = inv[7];
      rsp_data.r22      = inv[8];
      rsp_data.det_out  = det_out_ff.det;
      rsp_data.singular = sing_ff;
      rsp_data.overflow = det_out_ff.ovf | (|inv_ovf);
   end

endmodule

`default_nettype wire

// ----- rtl/mi3_cof_lane.sv -----
// One cofactor lane: two products of a 2x2 minor, then difference, sign and saturation.
// Depends on mi3_pkg.
`default_nettype none

module mi3_cof_lane (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              sign_neg,
   input  wire mi3_pkg::elem_type a,
   input  wire mi3_pkg::elem_type b,
   input  wire mi3_pkg::elem_type c,
   input  wire mi3_pkg::elem_type d,
   output mi3_pkg::elem_type      cof,
   output logic                   ovf
);
   import mi3_pkg::*;

   logic signed [2*ELEM_WIDTH-1:0] p0_ff, p1_ff;
   logic                           neg_ff;
   logic signed [ACC_W-1:0]        diff, mn;
   sat_type                        s;
   elem_type                       cof_ff;
   logic                           ovf_ff;

   always_comb begin
      diff = ACC_W'(p0_ff) - ACC_W'(p1_ff);
      mn   = neg_ff ? -diff : diff;
      s    = trunc_sat(mn);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= $signed(a) * $signed(d);
         p1_ff  <= $signed(b) * $signed(c);
         neg_ff <= sign_neg;
         cof_ff <= s.val;
         ovf_ff <= s.ovf;
      end
   end

   assign cof = cof_ff;
   assign ovf = ovf_ff;

endmodule

`default_nettype wire

// ----- rtl/mi3_det_merge.sv -----
// Merging stage: expands the determinant along row 0 from the cofactor lanes.
// Depends on mi3_pkg.
`default_nettype none

module mi3_det_merge (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire mi3_pkg::elem_type e0,
   input  wire mi3_pkg::elem_type e1,
   input  wire mi3_pkg::elem_type e2,
   input  wire mi3_pkg::elem_type c0,
   input  wire mi3_pkg::elem_type c1,
   input  wire mi3_pkg::elem_type c2,
   input  wire logic              cof_ovf,
   output mi3_pkg::det_bundle_type det
);
   import mi3_pkg::*;

   logic signed [2*ELEM_WIDTH-1:0] p0_ff, p1_ff, p2_ff;
   logic                           covf_ff;
   logic signed [ACC_W-1:0]        acc;
   sat_type                        s;
   det_bundle_type                 det_ff;

   always_comb begin
      acc = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff);
      s   = trunc_sat(acc);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff      <= $signed(e0) * $signed(c0);
         p1_ff      <= $signed(e1) * $signed(c1);
         p2_ff      <= $signed(e2) * $signed(c2);
         covf_ff    <= cof_ovf;
         det_ff.det <= s.val;
         det_ff.ovf <= covf_ff | s.ovf;
      end
   end

   assign det = det_ff;

endmodule

`default_nettype wire

// ----- rtl/mi3_recip_div.sv -----
// Pipelined restoring divider giving trunc(2^(2*FRAC_BITS) / det), one quotient bit a stage.
// Depends on mi3_pkg.
`default_nettype none

module mi3_recip_div (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire mi3_pkg::elem_type det,
   output mi3_pkg::recip_type     recip
);
   import mi3_pkg::*;

   logic [ELEM_WIDTH-1:0] dmag_ff [0:Q_W];
   logic                  neg_ff  [0:Q_W];
   logic [ELEM_WIDTH-1:0] rem_ff  [0:Q_W];
   logic [Q_W-1:0]        q_ff    [0:Q_W];
   recip_type             recip_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dmag_ff[0] <= det[ELEM_WIDTH-1] ? ELEM_WIDTH'(-det) : det;
         neg_ff[0]  <= det[ELEM_WIDTH-1];
         rem_ff[0]  <= '0;
         q_ff[0]    <= '0;
         recip_ff   <= neg_ff[Q_W] ? -$signed({1'b0, q_ff[Q_W]})
                                   : $signed({1'b0, q_ff[Q_W]});
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      // Only the top numerator bit is set, so the first stage shifts in a one.
      logic [ELEM_WIDTH:0] trial;
      logic                ge;
      always_comb begin
         trial = {rem_ff[k], (k == 0) ? 1'b1 : 1'b0};
         ge    = trial >= {1'b0, dmag_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? ELEM_WIDTH'(trial - {1'b0, dmag_ff[k]})
                               : trial[ELEM_WIDTH-1:0];
            q_ff[k+1]    <= {q_ff[k][Q_W-2:0], ge};
            dmag_ff[k+1] <= dmag_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
         end
      end
   end

   assign recip = recip_ff;

endmodule

`default_nettype wire

// ----- rtl/mi3_inv_lane.sv -----
// One inverse lane: adjugate entry times reciprocal, truncated and saturated, or zero if singular.
// Depends on mi3_pkg.
`default_nettype none

module mi3_inv_lane (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire mi3_pkg::elem_type  adj,
   input  wire mi3_pkg::recip_type recip,
   input  wire logic               singular,
   output mi3_pkg::elem_type       res,
   output logic                    ovf
);
   import mi3_pkg::*;

   logic signed [ELEM_WIDTH+RCP_W-1:0] prod_ff;
   sat_type                            s;
   elem_type                           res_ff;
   logic                               ovf_ff;

   always_comb s = trunc_sat(ACC_W'(prod_ff));

   // singular arrives aligned with the product register.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= $signed(adj) * $signed(recip);
         res_ff  <= singular ? '0 : s.val;
         ovf_ff  <= !singular && s.ovf;
      end
   end

   assign res = res_ff;
   assign ovf = ovf_ff;

endmodule

`default_nettype wire

// ----- bench/mi3_checker.sv -----
// Checker for the 3x3 adjugate inverse: watches both channels, predicts each result
// word from the accepted matrix and compares field by field. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire mi3_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire mi3_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   import mi3_pkg::*;

   localparam logic signed [127:0] ELEM_MAX = 128'sd2147483647;
   localparam logic signed [127:0] ELEM_MIN = -128'sd2147483648;

   rsp_type inverse_queue[$];

   // Toward-zero division by 2^16 followed by clamping to the element range.
   function automatic logic signed [31:0] scale_clamp(input logic signed [127:0] x,
                                                     inout logic ovf);
      logic signed [127:0] t;
      t = (x < 0) ? -((-x) >>> FRAC_BITS) : (x >>> FRAC_BITS);
      if (t > ELEM_MAX) begin
         ovf = 1'b1;
         return ELEM_MAX[31:0];
      end
      if (t < ELEM_MIN) begin
         ovf = 1'b1;
         return ELEM_MIN[31:0];
      end
      return t[31:0];
   endfunction

   function automatic rsp_type invert_matrix(input req_type m);
      logic signed [127:0] a[3][3];
      logic signed [127:0] cof[3][3];
      logic signed [127:0] mn, acc, recip, q;
      logic signed [31:0] det, inv[3][3];
      logic ovf;
      int r0, r1, c0, c1;
      rsp_type o;
      ovf = 1'b0;
      a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
      a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
      a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
      for (int i = 0; i < 3; i++) begin
         r0 = (i == 0) ? 1 : 0;
         r1 = (i == 2) ? 1 : 2;
         for (int j = 0; j < 3; j++) begin
            c0 = (j == 0) ? 1 : 0;
            c1 = (j == 2) ? 1 : 2;
            mn = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
            if (((i + j) % 2) == 1) mn = -mn;
            cof[i][j] = scale_clamp(mn, ovf);
         end
      end
      acc = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
      det = scale_clamp(acc, ovf);
      o = '0;
      if (det == 0) begin
         o.singular = 1'b1;
         o.overflow = ovf;
         return o;
      end
      q = (128'sd1 <<< (2 * FRAC_BITS)) / ((det < 0) ? -128'(det) : 128'(det));
      recip = (det < 0) ? -q : q;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            inv[i][j] = scale_clamp(cof[j][i] * recip, ovf);
      o.r00 = inv[0][0]; o.r01 = inv[0][1]; o.r02 = inv[0][2];
      o.r10 = inv[1][0]; o.r11 = inv[1][1]; o.r12 = inv[1][2];
      o.r20 = inv[2][0]; o.r21 = inv[2][1]; o.r22 = inv[2][2];
      o.det_out = det;
      o.overflow = ovf;
      return o;
   endfunction

   assign pending = inverse_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) inverse_queue.push_back(invert_matrix(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (inverse_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = inverse_queue.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10) begin
                     $display("mismatch r: exp %h %h %h %h %h %h %h %h %h", want.r00,
                              want.r01, want.r02, want.r10, want.r11, want.r12,
                              want.r20, want.r21, want.r22);
                     $display("           got %h %h %h %h %h %h %h %h %h", rsp_data.r00,
                              rsp_data.r01, rsp_data.r02, rsp_data.r10, rsp_data.r11,
                              rsp_data.r12, rsp_data.r20, rsp_data.r21, rsp_data.r22);
                     $display("   det/sing/ovf exp %h %b %b got %h %b %b", want.det_out,
                              want.singular, want.overflow, rsp_data.det_out,
                              rsp_data.singular, rsp_data.overflow);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- bench/tb_matrix3_inverse_adjugate.sv -----
// Top of the regression for the 3x3 adjugate inverse: clock, reset, stimulus and verdict.
// Depends on mi3_pkg, the block and mi3_checker.
`timescale 1ns / 1ps

module tb_matrix3_inverse_adjugate;
   import mi3_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count;

   matrix3_inverse_adjugate uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   mi3_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Random element: mostly small Q16.16 values so that inverses stay in range,
   // with full-width patterns now and then.
   function automatic elem_type pick_elem();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'sh8000_0000;
         2: return 32'sh7fff_ffff;
         3, 4: return $signed($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000;
         5: return 0;
         default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic req_type make_matrix(input int kind);
      req_type m;
      m = {pick_elem(), pick_elem(), pick_elem(), pick_elem(), pick_elem(),
           pick_elem(), pick_elem(), pick_elem(), pick_elem()};
      case (kind)
         1: begin
            // Repeated column: singular or nearly so.
            m.m02 = m.m00; m.m12 = m.m10; m.m22 = m.m20;
         end
         2: begin
            m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
         end
         3: m = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
         default: ;
      endcase
      return m;
   endfunction

   // Valid stays high between back-to-back words and drops only for an idle gap.
   task automatic send_matrix(input req_type m);
      int idle;
      idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_data  <= m;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver: a stall length per word, with calm stretches in between.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = ($urandom_range(0, 7) < 3) ? $urandom_range(0, 11) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("matrix3_inverse_adjugate regression: fail");
         $finish;
      end
   end

   initial begin
      req_type unit;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identity, other diagonal and mixed matrices, zero, extremes, singular cases.
      unit = '0;
      unit.m00 = 32'sh0001_0000; unit.m11 = 32'sh0001_0000; unit.m22 = 32'sh0001_0000;
      send_matrix(unit);
      unit.m00 = 32'sh0002_0000; unit.m11 = -32'sh0000_8000; unit.m22 = 32'sh0000_0100;
      send_matrix(unit);
      unit.m01 = 32'sh0000_3000; unit.m12 = -32'sh0001_8000; unit.m20 = 32'sh0000_1234;
      send_matrix(unit);
      send_matrix('0);
      send_matrix({9{32'sh7fff_ffff}});
      send_matrix({9{32'sh8000_0000}});
      send_matrix({9{32'shffff_ffff}});
      send_matrix({32'sh7fff_ffff, 32'sh0, 32'sh0, 32'sh0, 32'sh7fff_ffff, 32'sh0,
                   32'sh0, 32'sh0, 32'sh7fff_ffff});
      send_matrix({32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh8000_0000, 32'sh0,
                   32'sh0, 32'sh0, 32'sh8000_0000});
      // Tiny diagonal: nonzero exact determinant below one step.
      send_matrix({32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh0,
                   32'sh1});
      send_matrix({32'sh0000_0100, 32'sh0, 32'sh0, 32'sh0, 32'sh0000_0100, 32'sh0,
                   32'sh0, 32'sh0, 32'sh0000_0100});
      send_matrix(make_matrix(1));
      send_matrix(make_matrix(2));
      send_matrix({32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                   32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 32'sh0, 32'sh1});

      for (int n = 0; n < 1540; n++) begin
         if (n == 700) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         send_matrix(make_matrix($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3)));
      end
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
      if (fail_count == 0) begin
         $display("matrix3_inverse_adjugate regression: pass");
      end else begin
         $display("matrix3_inverse_adjugate regression: fail");
      end
      $finish;
   end

endmodule
